FILE: src/mhpq_pkg.sv
// Shared constants and types for the max-heap priority queue.
// Holds opcodes, status codes, the capacity register layout and the
// command/status structs between controller and datapath. No dependencies.
package mhpq_pkg;

    // capacity register
    localparam int              CAP_W     = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // request opcodes (any other code behaves as a peek)
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POLL   = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_INS_READ,
        DP_INS_MOVE,
        DP_INS_PLACE,
        DP_ROOT_READ,
        DP_POLL_TAKE,
        DP_PEEK_TAKE,
        DP_DN_READ,
        DP_DN_MOVE,
        DP_DN_PLACE,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    // flags reported back to the controller
    typedef struct packed {
        logic insert_req;   // request on the input port is an insert
        logic full;         // count at or above effective capacity
        logic empty;        // count is zero
        logic held_poll;    // accepted request was a poll
        logic at_root;      // hole position is the root
        logic parent_less;  // parent degree below the moving entry
        logic dn_move;      // a child beats the moving entry
    } dp_sts_t;

endpackage

FILE: src/max_heap_priority_queue.sv
// Max-heap priority queue on degree, with entries held in on-chip memory.
// Top level: joins mhpq_ctrl and mhpq_datapath; depends on mhpq_pkg.
//
// Use: a request (opcode, degree, coef, ident) is taken when in_valid is
// high and in_stall is low. opcode insert adds an entry, poll removes and
// returns the largest-degree entry, peek returns it and leaves it in place.
// Each request gives one result on out_* with status ok, full (insert
// dropped) or empty, plus entry_count and high_water_mark after the request.
// The capacity register is written through cfg_valid/cfg_data, always ready.
// Flow: one request at a time. An insert sifts the new entry up from its
// slot; a poll reads the root and the last entry, then sifts the last entry
// down from the root (no sift when it empties the heap); a peek returns the
// root without sifting. A sift walks at most log2(DEPTH) heap levels (10 at
// the default depth); each level takes a memory read, then a compare/write
// step. Full or empty requests go straight to the result. A result waiting under out_stall holds the
// output register; the next request is still taken and completes, then
// waits for that register to drain. Reset empties the heap, clears the
// high-water mark and sets capacity to 1024; no memory clearing pass runs.
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int DEGREE_BITS = 20,
    parameter int COEF_BITS   = 32,
    parameter int ID_BITS     = 12,
    localparam int CW         = $clog2(DEPTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             opcode,
    input  logic [DEGREE_BITS-1:0] degree,
    input  logic [COEF_BITS-1:0]   coef,
    input  logic [ID_BITS-1:0]     ident,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [DEGREE_BITS-1:0] out_degree,
    output logic [COEF_BITS-1:0]   out_coef,
    output logic [ID_BITS-1:0]     out_ident,
    output logic [1:0]             status,
    output logic [CW-1:0]          entry_count,
    output logic [CW-1:0]          high_water_mark,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // capacity writes never stall
    assign cfg_ready = 1'b1;

    // sequencer
    mhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // heap storage and arithmetic
    mhpq_datapath #(
        .DEPTH       (DEPTH),
        .DEGREE_BITS (DEGREE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .opcode          (opcode),
        .degree          (degree),
        .coef            (coef),
        .ident           (ident),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .out_degree      (out_degree),
        .out_coef        (out_coef),
        .out_ident       (out_ident),
        .status          (status),
        .entry_count     (entry_count),
        .high_water_mark (high_water_mark)
    );

endmodule

FILE: src/mhpq_datapath.sv
// Datapath of the max-heap priority queue: heap memory, count, high-water
// mark, capacity register, moving entry and result registers.
// Depends on mhpq_pkg; driven by mhpq_ctrl.
module mhpq_datapath
    import mhpq_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int DEGREE_BITS = 20,
    parameter int COEF_BITS   = 32,
    parameter int ID_BITS     = 12,
    localparam int CW         = $clog2(DEPTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_sts_t                sts,
    input  logic [1:0]             opcode,
    input  logic [DEGREE_BITS-1:0] degree,
    input  logic [COEF_BITS-1:0]   coef,
    input  logic [ID_BITS-1:0]     ident,
    input  logic                   cfg_valid,
    input  logic [CAP_W-1:0]       cfg_data,
    output logic [DEGREE_BITS-1:0] out_degree,
    output logic [COEF_BITS-1:0]   out_coef,
    output logic [ID_BITS-1:0]     out_ident,
    output logic [1:0]             status,
    output logic [CW-1:0]          entry_count,
    output logic [CW-1:0]          high_water_mark
);

    localparam int AW = $clog2(DEPTH);
    localparam int EW = DEGREE_BITS + COEF_BITS + ID_BITS;
    localparam int MW = (CW > CAP_W) ? CW : CAP_W;

    logic [EW-1:0]          mem [DEPTH];
    logic [CAP_W-1:0]       capacity_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          hwm_reg;
    logic                   poll_reg;
    logic [AW-1:0]          pos_reg;
    logic [EW-1:0]          item_reg;
    logic [EW-1:0]          root_reg;
    logic [1:0]             res_status_reg;
    logic [EW-1:0]          rd_a_reg;
    logic [EW-1:0]          rd_b_reg;
    logic [DEGREE_BITS-1:0] out_degree_reg;
    logic [COEF_BITS-1:0]   out_coef_reg;
    logic [ID_BITS-1:0]     out_ident_reg;
    logic [1:0]             out_status_reg;
    logic [CW-1:0]          out_count_reg;
    logic [CW-1:0]          out_hwm_reg;

    logic [MW-1:0]          cap_ext;
    logic [MW-1:0]          depth_ext;
    logic [MW-1:0]          cap_eff;
    logic                   full;
    logic                   empty;
    logic [CW-1:0]          count_inc;
    logic [AW-1:0]          parent_idx;
    logic [AW-1:0]          last_idx;
    logic [DEGREE_BITS-1:0] item_deg;
    logic [DEGREE_BITS-1:0] a_deg;
    logic [DEGREE_BITS-1:0] b_deg;
    logic [DEGREE_BITS-1:0] best_deg;
    logic [AW+1:0]          l_idx;
    logic [AW+1:0]          r_idx;
    logic [AW+1:0]          cnt_wide;
    logic                   l_big;
    logic                   r_big;
    logic [AW-1:0]          best_idx;
    logic [EW-1:0]          best_ent;
    logic                   rd_en;
    logic [AW-1:0]          rd_a_addr;
    logic [AW-1:0]          rd_b_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;

    // effective capacity and fill flags
    assign cap_ext   = MW'(capacity_reg);
    assign depth_ext = MW'(DEPTH);
    assign cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign full      = MW'(count_reg) >= cap_eff;
    assign empty     = (count_reg == '0);
    assign count_inc = count_reg + CW'(1);
    assign last_idx  = AW'(count_reg - CW'(1));

    // sift-up: parent of the hole
    assign parent_idx = (pos_reg - AW'(1)) >> 1;

    // sift-down: children of the hole and the winning one
    assign item_deg = item_reg[EW-1 -: DEGREE_BITS];
    assign a_deg    = rd_a_reg[EW-1 -: DEGREE_BITS];
    assign b_deg    = rd_b_reg[EW-1 -: DEGREE_BITS];
    assign l_idx    = (AW+2)'({pos_reg, 1'b1});
    assign r_idx    = l_idx + (AW+2)'(1);
    assign cnt_wide = (AW+2)'(count_reg);
    assign l_big    = (l_idx < cnt_wide) && (a_deg > item_deg);
    assign best_deg = l_big ? a_deg : item_deg;
    assign r_big    = (r_idx < cnt_wide) && (b_deg > best_deg);
    assign best_idx = r_big ? r_idx[AW-1:0] : l_idx[AW-1:0];
    assign best_ent = r_big ? rd_b_reg : rd_a_reg;

    // status back to the controller
    assign sts.insert_req  = (opcode == OP_INSERT);
    assign sts.full        = full;
    assign sts.empty       = empty;
    assign sts.held_poll   = poll_reg;
    assign sts.at_root     = (pos_reg == '0);
    assign sts.parent_less = (a_deg < item_deg);
    assign sts.dn_move     = l_big || r_big;

    // memory port decode
    always_comb
    begin
        rd_en     = 1'b0;
        rd_a_addr = '0;
        rd_b_addr = '0;
        wr_en     = 1'b0;
        wr_addr   = pos_reg;
        wr_data   = item_reg;
        unique case (cmd.op)
            DP_INS_READ:
            begin
                rd_en     = 1'b1;
                rd_a_addr = parent_idx;
                rd_b_addr = parent_idx;
            end
            DP_INS_MOVE:
            begin
                wr_en   = 1'b1;
                wr_data = rd_a_reg;
            end
            DP_INS_PLACE, DP_DN_PLACE:
            begin
                wr_en = 1'b1;
            end
            DP_ROOT_READ:
            begin
                rd_en     = 1'b1;
                rd_b_addr = last_idx;
            end
            DP_DN_READ:
            begin
                rd_en     = 1'b1;
                rd_a_addr = l_idx[AW-1:0];
                rd_b_addr = r_idx[AW-1:0];
            end
            DP_DN_MOVE:
            begin
                wr_en   = 1'b1;
                wr_data = best_ent;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // heap memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    // control state: capacity, count, high-water mark, held opcode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
            hwm_reg      <= '0;
            poll_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            case (cmd.op)
                DP_ACCEPT:
                begin
                    poll_reg <= (opcode == OP_POLL);
                end
                DP_INS_PLACE:
                begin
                    count_reg <= count_inc;
                    if (count_inc > hwm_reg)
                    begin
                        hwm_reg <= count_inc;
                    end
                end
                DP_POLL_TAKE:
                begin
                    count_reg <= count_reg - CW'(1);
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // moving entry, hole position and result registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_ACCEPT:
            begin
                item_reg <= {degree, coef, ident};
                pos_reg  <= AW'(count_reg);
                root_reg <= '0;
                if (opcode == OP_INSERT)
                begin
                    res_status_reg <= full ? ST_FULL : ST_OK;
                end
                else
                begin
                    res_status_reg <= empty ? ST_EMPTY : ST_OK;
                end
            end
            DP_INS_MOVE:
            begin
                pos_reg <= parent_idx;
            end
            DP_POLL_TAKE:
            begin
                root_reg <= rd_a_reg;
                item_reg <= rd_b_reg;
                pos_reg  <= '0;
            end
            DP_PEEK_TAKE:
            begin
                root_reg <= rd_a_reg;
            end
            DP_DN_MOVE:
            begin
                pos_reg <= best_idx;
            end
            DP_OUT:
            begin
                out_degree_reg <= root_reg[EW-1 -: DEGREE_BITS];
                out_coef_reg   <= root_reg[COEF_BITS+ID_BITS-1 -: COEF_BITS];
                out_ident_reg  <= root_reg[ID_BITS-1:0];
                out_status_reg <= res_status_reg;
                out_count_reg  <= count_reg;
                out_hwm_reg    <= hwm_reg;
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    assign out_degree      = out_degree_reg;
    assign out_coef        = out_coef_reg;
    assign out_ident       = out_ident_reg;
    assign status          = out_status_reg;
    assign entry_count     = out_count_reg;
    assign high_water_mark = out_hwm_reg;

    // checks
    a_hwm_covers_count: assert property (@(posedge clk) disable iff (!rst_n)
        hwm_reg >= count_reg)
        else $error("high-water mark below entry count");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond heap depth");

    a_place_increments: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_INS_PLACE |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert placement did not bump the count");

endmodule

FILE: src/mhpq_ctrl.sv
// Controller state machine of the max-heap priority queue: sequences the
// insert sift-up, the poll sift-down and the result handshake.
// Depends on mhpq_pkg; drives mhpq_datapath.
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_ROOT_RD,
        S_ROOT_TAKE,
        S_DN_CHK,
        S_DN_CMP,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state and datapath command
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = DP_ACCEPT;
                    if (sts.insert_req)
                    begin
                        state_next = sts.full ? S_RESULT : S_INS_CHK;
                    end
                    else
                    begin
                        state_next = sts.empty ? S_RESULT : S_ROOT_RD;
                    end
                end
            end
            S_INS_CHK:
            begin
                if (sts.at_root)
                begin
                    cmd.op     = DP_INS_PLACE;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = DP_INS_READ;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (sts.parent_less)
                begin
                    cmd.op     = DP_INS_MOVE;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    cmd.op     = DP_INS_PLACE;
                    state_next = S_RESULT;
                end
            end
            S_ROOT_RD:
            begin
                cmd.op     = DP_ROOT_READ;
                state_next = S_ROOT_TAKE;
            end
            S_ROOT_TAKE:
            begin
                if (sts.held_poll)
                begin
                    cmd.op     = DP_POLL_TAKE;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    cmd.op     = DP_PEEK_TAKE;
                    state_next = S_RESULT;
                end
            end
            S_DN_CHK:
            begin
                // heap emptied by this poll: nothing to sift
                if (sts.empty)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = DP_DN_READ;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (sts.dn_move)
                begin
                    cmd.op     = DP_DN_MOVE;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    cmd.op     = DP_DN_PLACE;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = DP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // checks
    a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESULT && (!out_valid_reg || !out_stall) |=> out_valid_reg)
        else $error("result slot free but no result presented");

    a_valid_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESULT)
        else $error("result raised outside the result state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != S_IDLE)
        else $error("accepted request left the controller idle");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for max_heap_priority_queue: a local heap predictor,
// a queue-fed request driver, a result monitor and capacity register writes.
// Depends on mhpq_pkg and the max_heap_priority_queue RTL.
module tb_top;
    import mhpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 1024;
    localparam int DEGREE_BITS = 20;
    localparam int COEF_BITS   = 32;
    localparam int ID_BITS     = 12;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;
    // unused opcode, which the block treats as a peek
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [DEGREE_BITS-1:0] deg;
        logic [COEF_BITS-1:0]   cf;
        logic [ID_BITS-1:0]     id;
    } heap_entry_t;

    typedef struct packed {
        logic [DEGREE_BITS-1:0] deg;
        logic [COEF_BITS-1:0]   cf;
        logic [ID_BITS-1:0]     id;
        logic [1:0]             st;
        logic [CW-1:0]          cnt;
        logic [CW-1:0]          peak;
    } heap_result_t;

    typedef struct {
        logic [1:0]             op;
        logic [DEGREE_BITS-1:0] deg;
        logic [COEF_BITS-1:0]   cf;
        logic [ID_BITS-1:0]     id;
        bit                     drain;  // hold the sender until all results are back
    } heap_req_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             opcode = OP_INSERT;
    logic [DEGREE_BITS-1:0] degree = '0;
    logic [COEF_BITS-1:0]   coef = '0;
    logic [ID_BITS-1:0]     ident = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [DEGREE_BITS-1:0] out_degree;
    logic [COEF_BITS-1:0]   out_coef;
    logic [ID_BITS-1:0]     out_ident;
    logic [1:0]             status;
    logic [CW-1:0]          entry_count;
    logic [CW-1:0]          high_water_mark;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data = '0;

    // predictor state
    heap_entry_t      heap_mem [0:DEPTH-1];
    int               heap_cnt = 0;
    int               heap_peak = 0;
    logic [CAP_W-1:0] cap_reg = CAP_RESET;

    heap_req_t    pending_q [$];
    heap_result_t expected_q [$];
    heap_req_t    drv_req;
    heap_result_t mon_exp;

    int  queued_cnt = 0;
    int  sent_cnt = 0;
    int  checked_cnt = 0;
    int  err_cnt = 0;
    int  cycle_cnt = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;

    max_heap_priority_queue DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .degree          (degree),
        .coef            (coef),
        .ident           (ident),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_degree      (out_degree),
        .out_coef        (out_coef),
        .out_ident       (out_ident),
        .status          (status),
        .entry_count     (entry_count),
        .high_water_mark (high_water_mark),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    // ---------------------------------------------------------------
    // Heap predictor
    // ---------------------------------------------------------------
    function automatic void swap_slots(input int a, input int b);
        heap_entry_t t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    // apply one request to the predicted heap and return its result
    function automatic heap_result_t heap_apply(input logic [1:0] op,
                                                input logic [DEGREE_BITS-1:0] deg,
                                                input logic [COEF_BITS-1:0] cf,
                                                input logic [ID_BITS-1:0] id);
        heap_result_t res;
        int           lim;
        int           pos;
        int           up;
        int           lc;
        int           rc;
        int           best;
        res = '0;
        lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        if (op == OP_INSERT) begin
            if (heap_cnt >= lim) begin
                res.st = ST_FULL;
            end
            else begin
                heap_mem[heap_cnt] = '{deg: deg, cf: cf, id: id};
                pos = heap_cnt;
                heap_cnt++;
                // sift up while the parent is strictly smaller
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (heap_mem[up].deg < heap_mem[pos].deg) begin
                        swap_slots(up, pos);
                        pos = up;
                    end
                    else
                        break;
                end
                if (heap_cnt > heap_peak)
                    heap_peak = heap_cnt;
            end
        end
        else if (heap_cnt == 0) begin
            res.st = ST_EMPTY;
        end
        else begin
            res.deg = heap_mem[0].deg;
            res.cf  = heap_mem[0].cf;
            res.id  = heap_mem[0].id;
            if (op == OP_POLL) begin
                heap_mem[0] = heap_mem[heap_cnt - 1];
                heap_cnt--;
                // sift down; right child only wins when strictly larger
                pos = 0;
                forever begin
                    lc   = 2 * pos + 1;
                    rc   = 2 * pos + 2;
                    best = pos;
                    if (lc < heap_cnt && heap_mem[lc].deg > heap_mem[pos].deg)
                        best = lc;
                    if (rc < heap_cnt && heap_mem[rc].deg > heap_mem[best].deg)
                        best = rc;
                    if (best == pos)
                        break;
                    swap_slots(pos, best);
                    pos = best;
                end
            end
        end
        res.cnt  = heap_cnt[CW-1:0];
        res.peak = heap_peak[CW-1:0];
        return res;
    endfunction

    task automatic report(input string msg);
        err_cnt++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_q.push_back(heap_apply(opcode, degree, coef, ident));
                sent_cnt++;
            end
            // a stalled request holds; otherwise choose what to present next
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0 && pending_q[0].drain) begin
                    in_valid <= 1'b0;
                    if (expected_q.size() == 0)
                        void'(pending_q.pop_front());
                end
                else if (pending_q.size() > 0) begin
                    if (!quiet && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(0, 14);
                        in_valid <= 1'b0;
                    end
                    else begin
                        drv_req = pending_q.pop_front();
                        in_valid <= 1'b1;
                        opcode   <= drv_req.op;
                        degree   <= drv_req.deg;
                        coef     <= drv_req.cf;
                        ident    <= drv_req.id;
                    end
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and output stall
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report("result arrived with nothing expected");
                end
                else begin
                    mon_exp = expected_q.pop_front();
                    if (out_degree !== mon_exp.deg)
                        report($sformatf("result %0d out_degree got %0h want %0h",
                                         checked_cnt, out_degree, mon_exp.deg));
                    if (out_coef !== mon_exp.cf)
                        report($sformatf("result %0d out_coef got %0h want %0h",
                                         checked_cnt, out_coef, mon_exp.cf));
                    if (out_ident !== mon_exp.id)
                        report($sformatf("result %0d out_ident got %0h want %0h",
                                         checked_cnt, out_ident, mon_exp.id));
                    if (status !== mon_exp.st)
                        report($sformatf("result %0d status got %0d want %0d",
                                         checked_cnt, status, mon_exp.st));
                    if (entry_count !== mon_exp.cnt)
                        report($sformatf("result %0d entry_count got %0d want %0d",
                                         checked_cnt, entry_count, mon_exp.cnt));
                    if (high_water_mark !== mon_exp.peak)
                        report($sformatf("result %0d high_water_mark got %0d want %0d",
                                         checked_cnt, high_water_mark, mon_exp.peak));
                end
                checked_cnt++;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 14);
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic add_req(input logic [1:0] op, input logic [DEGREE_BITS-1:0] deg,
                           input logic [COEF_BITS-1:0] cf, input logic [ID_BITS-1:0] id);
        heap_req_t r;
        r = '{op: op, deg: deg, cf: cf, id: id, drain: 1'b0};
        pending_q.push_back(r);
        queued_cnt++;
    endtask

    task automatic add_drain();
        heap_req_t r;
        r = '{op: OP_PEEK, deg: '0, cf: '0, id: '0, drain: 1'b1};
        pending_q.push_back(r);
    endtask

    // random requests by weight; at least n, and more until min_ins inserts are queued
    task automatic gen_random(input int n, input int ins_w, input int poll_w,
                              input int peek_w, input int min_ins);
        int                     i;
        int                     ins;
        int                     pick;
        logic [1:0]             op;
        logic [DEGREE_BITS-1:0] deg;
        i   = 0;
        ins = 0;
        while (i < n || ins < min_ins) begin
            pick = $urandom_range(0, ins_w + poll_w + peek_w - 1);
            if (pick < ins_w) begin
                op = OP_INSERT;
                ins++;
            end
            else if (pick < ins_w + poll_w)
                op = OP_POLL;
            else
                op = ($urandom_range(0, 1) != 0) ? OP_PEEK : OP_SPARE;
            case ($urandom_range(0, 9))
                0:       deg = '0;
                1:       deg = '1;
                2, 3, 4: deg = DEGREE_BITS'($urandom_range(0, 15));
                default: deg = DEGREE_BITS'($urandom);
            endcase
            if ($urandom_range(0, 79) == 0)
                add_drain();
            add_req(op, deg, $urandom, ID_BITS'($urandom_range(0, 4095)));
            i++;
        end
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_reg = v;
        cfg_valid <= 1'b0;
    endtask

    // wait until every queued request is sent and every result is back
    task automatic wait_idle();
        while (sent_cnt != queued_cnt || expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty heap, extreme fields, ties, spare opcode
        add_req(OP_POLL, '1, '1, '1);
        add_req(OP_PEEK, '0, '0, '0);
        add_req(OP_SPARE, '1, '0, '1);
        add_req(OP_INSERT, '1, '1, '1);
        add_req(OP_INSERT, '0, '0, '0);
        add_req(OP_INSERT, 20'd5, 32'd1, 12'd1);
        add_req(OP_INSERT, 20'd5, 32'd2, 12'd2);
        add_req(OP_INSERT, 20'd5, 32'd3, 12'd3);
        add_req(OP_INSERT, '1, 32'hA5A5_A5A5, 12'h5A5);
        add_req(OP_PEEK, '0, '0, '0);
        add_req(OP_SPARE, '0, '0, '0);
        repeat (6) add_req(OP_POLL, '0, '0, '0);
        add_req(OP_POLL, '0, '0, '0);
        add_req(OP_INSERT, 20'h55555, 32'h5555_5555, 12'hAAA);
        add_drain();
        add_req(OP_INSERT, 20'hAAAAA, 32'hAAAA_AAAA, 12'h555);
        add_req(OP_POLL, '0, '0, '0);
        add_req(OP_POLL, '0, '0, '0);
        wait_idle();

        // capacity of one, then zero, then a handful
        set_capacity(CAP_W'(1));
        gen_random(30, 50, 30, 20, 0);
        wait_idle();
        set_capacity(CAP_W'(0));
        gen_random(20, 70, 20, 10, 0);
        wait_idle();
        set_capacity(CAP_W'(5));
        gen_random(120, 50, 35, 15, 0);
        wait_idle();

        // capacity above the depth, clamped to the store size: build a heap
        set_capacity('1);
        gen_random(110, 92, 0, 8, 0);
        wait_idle();

        // capacity lowered under the current count
        set_capacity(CAP_W'(60));
        gen_random(150, 40, 50, 10, 0);
        wait_idle();

        // back to the reset capacity; final stretch unthrottled
        set_capacity(CAP_RESET);
        gen_random(200, 50, 40, 10, 0);
        while (sent_cnt != queued_cnt)
            @(posedge clk);
        quiet = 1'b1;
        gen_random(100, 50, 40, 10, 0);
        wait_idle();
        repeat (SETTLE) @(posedge clk);

        if (expected_q.size() != 0)
            report($sformatf("%0d results never arrived", expected_q.size()));
        $display("Sent %0d requests and checked %0d results, high-water mark %0d,",
                 sent_cnt, checked_cnt, heap_peak);
        $display("under capacities 0, 1, 5, 60, 1024 and 2047 with random stalls.");
        if (err_cnt == 0)
            $display("[max_heap_priority_queue] OK");
        else
            $display("[max_heap_priority_queue] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_cnt, expected_q.size());
        $display("[max_heap_priority_queue] ERROR");
        $finish;
    end

endmodule
